[rtl/core/ipv4rx_pkg.sv]
// ----------------------------------------------------------------------------
// ipv4rx_pkg
// Shared types and constants for the IPv4 receive header filter.
// ----------------------------------------------------------------------------
package ipv4rx_pkg;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOCAL_ADDR  = 2'd0,
        CFG_SUBNET_MASK = 2'd1,
        CFG_IS_LOOPBACK = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        VERDICT_TCP         = 3'd0,
        VERDICT_UDP         = 3'd1,
        VERDICT_SHORT       = 3'd2,
        VERDICT_BAD_HEADER  = 3'd3,
        VERDICT_CHECKSUM    = 3'd4,
        VERDICT_DESTINATION = 3'd5,
        VERDICT_OTHER_PROTO = 3'd6
    } verdict_t;

    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [3:0]  IP_VERSION_4    = 4'd4;
    localparam logic [3:0]  MIN_IHL         = 4'd5;
    localparam logic [15:0] MIN_HDR_BYTES   = 16'd20;
    localparam logic [15:0] CSUM_GOOD       = 16'hFFFF;
    localparam logic [31:0] ADDR_ALL_ONES   = 32'hFFFF_FFFF;

    // header byte offsets
    localparam logic [15:0] POS_VER_IHL     = 16'd0;
    localparam logic [15:0] POS_PROTO       = 16'd9;
    localparam logic [15:0] POS_SRC_FIRST   = 16'd12;
    localparam logic [15:0] POS_DST_FIRST   = 16'd16;
    localparam logic [15:0] POS_DST_END     = 16'd20;

    // fields of a finished packet, handed from the parser to the judge stage
    typedef struct packed {
        logic [3:0]  version;
        logic [3:0]  ihl;
        logic [15:0] csum;
        logic [7:0]  proto;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] byte_count;
    } pkt_info_t;

endpackage

[rtl/core/ipv4rx_parse.sv]
// ----------------------------------------------------------------------------
// ipv4rx_parse
// Per-byte header capture and ones' complement sum; snapshots the packet
// state on the last beat and clears for the next packet.
// ----------------------------------------------------------------------------
module ipv4rx_parse
    import ipv4rx_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        snap_valid,
    input  logic        snap_ready,
    output pkt_info_t   snap
);

    localparam logic [15:0] COUNT_MAX = 16'(MAX_PACKET_BYTES);

    logic [15:0] count_reg, count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  pend_reg, pend_next;
    logic [3:0]  ver_reg, ver_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic        snap_valid_reg;
    pkt_info_t   snap_reg;

    logic [5:0]  hdr_len;
    logic        in_hdr;
    logic [16:0] sum_wide;
    logic        accept;

    assign s_ready = !snap_valid_reg || snap_ready;
    assign accept  = s_valid && s_ready;

    assign hdr_len  = {ihl_reg, 2'b00};
    assign in_hdr   = (count_reg == POS_VER_IHL) || (count_reg < {10'd0, hdr_len});
    assign sum_wide = {1'b0, sum_reg} + {1'b0, pend_reg, s_data_byte};

    always_comb begin
        ver_next   = ver_reg;
        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        pend_next  = pend_reg;
        sum_next   = sum_reg;

        if (count_reg == POS_VER_IHL) begin
            ver_next = s_data_byte[7:4];
            ihl_next = s_data_byte[3:0];
        end else if (count_reg == POS_PROTO) begin
            proto_next = s_data_byte;
        end else if (count_reg >= POS_SRC_FIRST && count_reg < POS_DST_FIRST) begin
            src_next = {src_reg[23:0], s_data_byte};
        end else if (count_reg >= POS_DST_FIRST && count_reg < POS_DST_END) begin
            dst_next = {dst_reg[23:0], s_data_byte};
        end

        if (in_hdr) begin
            if (!count_reg[0]) begin
                pend_next = s_data_byte;
            end else begin
                // end-around carry; cannot carry twice
                sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
            end
        end

        count_next = (count_reg < COUNT_MAX) ? count_reg + 16'd1 : count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            sum_reg        <= '0;
            pend_reg       <= '0;
            ver_reg        <= '0;
            ihl_reg        <= '0;
            proto_reg      <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end else begin
            if (accept && s_last_byte) begin
                count_reg      <= '0;
                sum_reg        <= '0;
                pend_reg       <= '0;
                ver_reg        <= '0;
                ihl_reg        <= '0;
                proto_reg      <= '0;
                src_reg        <= '0;
                dst_reg        <= '0;
                snap_valid_reg <= 1'b1;
            end else begin
                if (accept) begin
                    count_reg <= count_next;
                    sum_reg   <= sum_next;
                    pend_reg  <= pend_next;
                    ver_reg   <= ver_next;
                    ihl_reg   <= ihl_next;
                    proto_reg <= proto_next;
                    src_reg   <= src_next;
                    dst_reg   <= dst_next;
                end
                if (snap_ready) begin
                    snap_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_byte) begin
            snap_reg.version    <= ver_next;
            snap_reg.ihl        <= ihl_next;
            snap_reg.csum       <= sum_next;
            snap_reg.proto      <= proto_next;
            snap_reg.src_ip     <= src_next;
            snap_reg.dst_ip     <= dst_next;
            snap_reg.byte_count <= count_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

[rtl/core/ipv4_receive_header_filter.sv]
// ----------------------------------------------------------------------------
// ipv4_receive_header_filter
// IPv4 receive header checks: length, version/IHL, checksum, destination,
// protocol, one verdict per packet.
// ----------------------------------------------------------------------------
// Packet bytes enter one per beat in wire order, with s_last_byte on the final
// beat; a new byte is taken every cycle unless the result side backs up. The
// parser register captures each byte and updates the header sum in the same
// cycle; the last beat is snapshotted at its accepting edge, judged
// combinationally from the snapshot and registered onto the result channel
// once that channel can take it. The input only stalls while both the
// snapshot and the result register are full and the result is not taken.
// Throughput is one byte per cycle unless the result side backs up. The
// header sum uses an end-around carry. Configuration must only be written
// while no packet is in flight.
module ipv4_receive_header_filter
    import ipv4rx_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = 65535
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_last_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_verdict,
    output logic [7:0]             m_protocol_number,
    output logic [31:0]            m_source_address,
    output logic [31:0]            m_dest_address,
    output logic [5:0]             m_header_bytes,
    output logic [15:0]            m_packet_bytes
);

    logic [31:0] local_addr_reg;
    logic [31:0] subnet_mask_reg;
    logic        is_loopback_reg;

    logic        snap_valid;
    logic        snap_ready;
    pkt_info_t   snap;

    logic        m_valid_reg;
    verdict_t    verdict_next;
    verdict_t    verdict_reg;
    logic [7:0]  proto_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [5:0]  hdr_bytes_reg;
    logic [15:0] pkt_bytes_reg;

    logic [5:0]  hdr_len;
    logic        dst_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_addr_reg  <= '0;
            subnet_mask_reg <= '0;
            is_loopback_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LOCAL_ADDR:  local_addr_reg  <= cfg_wdata;
                CFG_SUBNET_MASK: subnet_mask_reg <= cfg_wdata;
                CFG_IS_LOOPBACK: is_loopback_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    ipv4rx_parse #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data_byte(s_data_byte),
        .s_last_byte(s_last_byte),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    assign snap_ready = !m_valid_reg || m_ready;
    assign hdr_len    = {snap.ihl, 2'b00};

    assign dst_ok = is_loopback_reg
                 || (snap.dst_ip == local_addr_reg)
                 || (snap.dst_ip == ADDR_ALL_ONES)
                 || ((snap.dst_ip | subnet_mask_reg) == ADDR_ALL_ONES);

    always_comb begin
        if (snap.byte_count < MIN_HDR_BYTES || snap.byte_count < {10'd0, hdr_len}) begin
            verdict_next = VERDICT_SHORT;
        end else if (snap.version != IP_VERSION_4 || snap.ihl < MIN_IHL) begin
            verdict_next = VERDICT_BAD_HEADER;
        end else if (snap.csum != CSUM_GOOD) begin
            verdict_next = VERDICT_CHECKSUM;
        end else if (!dst_ok) begin
            verdict_next = VERDICT_DESTINATION;
        end else if (snap.proto == PROTO_TCP) begin
            verdict_next = VERDICT_TCP;
        end else if (snap.proto == PROTO_UDP) begin
            verdict_next = VERDICT_UDP;
        end else begin
            verdict_next = VERDICT_OTHER_PROTO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (snap_ready) begin
            m_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid && snap_ready) begin
            verdict_reg   <= verdict_next;
            proto_reg     <= snap.proto;
            src_reg       <= snap.src_ip;
            dst_reg       <= snap.dst_ip;
            hdr_bytes_reg <= hdr_len;
            pkt_bytes_reg <= snap.byte_count;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_verdict         = verdict_reg;
    assign m_protocol_number = proto_reg;
    assign m_source_address  = src_reg;
    assign m_dest_address    = dst_reg;
    assign m_header_bytes    = hdr_bytes_reg;
    assign m_packet_bytes    = pkt_bytes_reg;

`ifndef SYNTHESIS
    // input back-pressure only ever comes from a held result
    a_stall_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && !m_ready))
        else $error("input stalled without a held result");

    a_tcp_proto: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_verdict == VERDICT_TCP) |-> (m_protocol_number == PROTO_TCP))
        else $error("TCP verdict with wrong protocol byte");

    a_long_enough: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_verdict != VERDICT_SHORT) |-> (m_packet_bytes >= MIN_HDR_BYTES))
        else $error("short packet passed length check");

    a_hdr_checked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_verdict != VERDICT_SHORT && m_verdict != VERDICT_BAD_HEADER)
            |-> (m_header_bytes >= 6'd20 && {10'd0, m_header_bytes} <= m_packet_bytes))
        else $error("header length not checked before later verdicts");

    a_result_follows_snap: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid && snap_ready) |=> m_valid)
        else $error("snapshot lost on the way to the result register");
`endif

endmodule

[test/ipv4_receive_header_filter_tb.sv]
// ----------------------------------------------------------------------------
// ipv4_receive_header_filter_tb
// Self-checking bench for the IPv4 receive header filter. Packets are built
// byte by byte (headers with real checksums, then corrupted, truncated or
// replaced by noise), a bench-side parser predicts each verdict, and every
// result beat is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ipv4_receive_header_filter_tb;
    import ipv4rx_pkg::*;

    localparam int unsigned PKT_BYTES_MAX   = 65535;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned SETTLE_CYCLES   = 6;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned WATCHDOG_LIMIT  = 4000;
    localparam int unsigned MAX_REPORTS     = 10;

    typedef struct packed {
        verdict_t    verdict;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [5:0]  hdr_bytes;
        logic [15:0] pkt_bytes;
    } ip_verdict_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata   = '0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_data_byte = '0;
    logic                   s_last_byte = 1'b0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    logic [2:0]             m_verdict;
    logic [7:0]             m_protocol_number;
    logic [31:0]            m_source_address;
    logic [31:0]            m_dest_address;
    logic [5:0]             m_header_bytes;
    logic [15:0]            m_packet_bytes;

    // interface settings as last written
    logic [31:0] cfg_local = '0;
    logic [31:0] cfg_mask  = '0;
    logic        cfg_loop  = 1'b0;

    // per-packet parser state
    logic [15:0] rx_count = '0;
    logic [15:0] hdr_sum  = '0;
    logic [7:0]  hi_byte  = '0;
    logic [3:0]  rx_ver   = '0;
    logic [3:0]  rx_ihl   = '0;
    logic [7:0]  rx_proto = '0;
    logic [31:0] rx_src   = '0;
    logic [31:0] rx_dst   = '0;

    ip_verdict_t pending_verdicts[$];
    logic [7:0]  frame[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    int unsigned errors        = 0;

    ipv4_receive_header_filter i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_verdict         (m_verdict),
        .m_protocol_number (m_protocol_number),
        .m_source_address  (m_source_address),
        .m_dest_address    (m_dest_address),
        .m_header_bytes    (m_header_bytes),
        .m_packet_bytes    (m_packet_bytes)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ones' complement add with end-around carry
    function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = a + b;
        return s[15:0] + s[16];
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic last);
        ip_verdict_t r;
        int unsigned pos;
        pos = rx_count;
        if (pos == POS_VER_IHL) begin
            rx_ver = b[7:4];
            rx_ihl = b[3:0];
        end else if (pos == POS_PROTO) begin
            rx_proto = b;
        end else if (pos >= POS_SRC_FIRST && pos < POS_DST_FIRST) begin
            rx_src = {rx_src[23:0], b};
        end else if (pos >= POS_DST_FIRST && pos < POS_DST_END) begin
            rx_dst = {rx_dst[23:0], b};
        end
        // first byte always joins the sum, the rest only inside the header
        if (pos == 0 || pos < rx_ihl * 4) begin
            if (pos % 2 == 0)
                hi_byte = b;
            else
                hdr_sum = oc_add(hdr_sum, {hi_byte, b});
        end
        if (rx_count != PKT_BYTES_MAX)
            rx_count++;
        if (last) begin
            if (rx_count < MIN_HDR_BYTES || rx_count < rx_ihl * 4)
                r.verdict = VERDICT_SHORT;
            else if (rx_ver != IP_VERSION_4 || rx_ihl < MIN_IHL)
                r.verdict = VERDICT_BAD_HEADER;
            else if (hdr_sum != CSUM_GOOD)
                r.verdict = VERDICT_CHECKSUM;
            else if (!cfg_loop && rx_dst != cfg_local && rx_dst != ADDR_ALL_ONES &&
                     (rx_dst | cfg_mask) != ADDR_ALL_ONES)
                r.verdict = VERDICT_DESTINATION;
            else if (rx_proto == PROTO_TCP)
                r.verdict = VERDICT_TCP;
            else if (rx_proto == PROTO_UDP)
                r.verdict = VERDICT_UDP;
            else
                r.verdict = VERDICT_OTHER_PROTO;
            r.proto     = rx_proto;
            r.src       = rx_src;
            r.dst       = rx_dst;
            r.hdr_bytes = {rx_ihl, 2'b00};
            r.pkt_bytes = rx_count;
            pending_verdicts.push_back(r);
            rx_count = '0;
            hdr_sum  = '0;
            hi_byte  = '0;
            rx_ver   = '0;
            rx_ihl   = '0;
            rx_proto = '0;
            rx_src   = '0;
            rx_dst   = '0;
        end
    endfunction

    // header with a correct checksum unless bad_csum; IHL below 5 still gets
    // the 20 fixed bytes
    function automatic void build_packet(logic [3:0] ver, logic [3:0] ihl,
                                         logic [7:0] proto, logic [31:0] src,
                                         logic [31:0] dst, int unsigned payload,
                                         logic bad_csum);
        int unsigned hdr_len;
        logic [15:0] sum;
        hdr_len = (ihl < MIN_IHL) ? 20 : ihl * 4;
        frame.delete();
        for (int i = 0; i < hdr_len; i++)
            frame.push_back(8'($urandom));
        frame[0]  = {ver, ihl};
        frame[9]  = proto;
        frame[10] = 8'h00;
        frame[11] = 8'h00;
        for (int k = 0; k < 4; k++) begin
            frame[12 + k] = src[31 - 8 * k -: 8];
            frame[16 + k] = dst[31 - 8 * k -: 8];
        end
        sum = 16'h0000;
        for (int i = 0; i < hdr_len; i += 2)
            sum = oc_add(sum, {frame[i], frame[i + 1]});
        sum = ~sum;
        if (bad_csum)
            sum ^= 16'(1 << $urandom_range(15));
        frame[10] = sum[15:8];
        frame[11] = sum[7:0];
        repeat (payload) frame.push_back(8'($urandom));
    endfunction

    function automatic void trim_frame(int unsigned keep);
        while (frame.size() > keep)
            void'(frame.pop_back());
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_byte(b, last);
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    // drop valid, let outstanding verdicts drain and the judge stage settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_interface(logic [31:0] addr, logic [31:0] mask, logic loopback);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LOCAL_ADDR;
        cfg_wdata <= addr;
        @(posedge aclk);
        cfg_index <= CFG_SUBNET_MASK;
        cfg_wdata <= mask;
        @(posedge aclk);
        // upper bits are junk, only bit 0 counts
        cfg_index <= CFG_IS_LOOPBACK;
        cfg_wdata <= {31'($urandom), loopback};
        @(posedge aclk);
        // unmapped index must leave everything alone
        cfg_index <= CFG_UNUSED;
        cfg_wdata <= $urandom;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_local = addr;
        cfg_mask  = mask;
        cfg_loop  = loopback;
    endtask

    task automatic test_verdict_paths();
        build_packet(IP_VERSION_4, MIN_IHL, PROTO_TCP, 32'h0, cfg_local, 0, 1'b0);
        send_frame();
        // full 60-byte header to the limited broadcast
        build_packet(IP_VERSION_4, 4'd15, PROTO_UDP, ADDR_ALL_ONES, ADDR_ALL_ONES, 4, 1'b0);
        send_frame();
        build_packet(IP_VERSION_4, MIN_IHL, 8'hFF, $urandom, cfg_local | ~cfg_mask, 2, 1'b0);
        send_frame();
        build_packet(IP_VERSION_4, 4'd6, 8'h00, $urandom, cfg_local, 1, 1'b0);
        send_frame();
        build_packet(IP_VERSION_4, MIN_IHL, PROTO_TCP, $urandom, cfg_local ^ 32'h100, 0, 1'b0);
        send_frame();
        build_packet(IP_VERSION_4, MIN_IHL, PROTO_UDP, $urandom, cfg_local, 3, 1'b1);
        send_frame();
        build_packet(4'd6, MIN_IHL, PROTO_TCP, $urandom, cfg_local, 0, 1'b0);
        send_frame();
        build_packet(IP_VERSION_4, 4'd4, PROTO_TCP, $urandom, cfg_local, 0, 1'b0);
        send_frame();
        build_packet(IP_VERSION_4, 4'd0, PROTO_TCP, $urandom, cfg_local, 0, 1'b0);
        send_frame();
    endtask

    task automatic test_short_packets();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        // one byte short of the fixed header
        build_packet(IP_VERSION_4, MIN_IHL, PROTO_TCP, $urandom, cfg_local, 0, 1'b0);
        trim_frame(19);
        send_frame();
        // past 20 bytes but short of a 32-byte header
        build_packet(IP_VERSION_4, 4'd8, PROTO_UDP, $urandom, cfg_local, 0, 1'b0);
        trim_frame(24);
        send_frame();
    endtask

    task automatic test_destination_rules();
        set_interface(cfg_local, cfg_mask, 1'b1);
        build_packet(IP_VERSION_4, MIN_IHL, PROTO_TCP, $urandom, $urandom, 0, 1'b0);
        send_frame();
        // all-ones mask lets any destination through as subnet broadcast
        set_interface(ADDR_ALL_ONES, ADDR_ALL_ONES, 1'b0);
        build_packet(IP_VERSION_4, MIN_IHL, PROTO_UDP, $urandom, $urandom, 0, 1'b0);
        send_frame();
        set_interface(32'h0, 32'h0, 1'b0);
        build_packet(IP_VERSION_4, MIN_IHL, PROTO_TCP, $urandom, 32'h0, 0, 1'b0);
        send_frame();
        build_packet(IP_VERSION_4, MIN_IHL, PROTO_TCP, $urandom, 32'h0A00_0001, 0, 1'b0);
        send_frame();
        build_packet(IP_VERSION_4, MIN_IHL, PROTO_UDP, $urandom, ADDR_ALL_ONES, 0, 1'b0);
        send_frame();
    endtask

    task automatic test_random_traffic(int unsigned packets);
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [31:0] dst;
        repeat (packets) begin
            ver = ($urandom_range(19) == 0) ? 4'($urandom) : IP_VERSION_4;
            ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : MIN_IHL;
            if ($urandom_range(19) == 0)
                ihl = 4'($urandom_range(4));
            case ($urandom_range(3))
                0: proto = PROTO_TCP;
                1: proto = PROTO_UDP;
                default: proto = 8'($urandom);
            endcase
            case ($urandom_range(4))
                0: dst = cfg_local;
                1: dst = ADDR_ALL_ONES;
                2: dst = cfg_local | ~cfg_mask;
                default: dst = $urandom;
            endcase
            build_packet(ver, ihl, proto, $urandom, dst, $urandom_range(8),
                         $urandom_range(9) == 0);
            if ($urandom_range(9) == 0)
                trim_frame($urandom_range(frame.size() - 1, 1));
            // noise: arbitrary bytes of arbitrary length
            if ($urandom_range(6) == 0) begin
                frame.delete();
                repeat ($urandom_range(40, 1)) frame.push_back(8'($urandom));
            end
            send_frame();
        end
    endtask

    // receiver stops for a long while; the filter has to back up its input
    task automatic test_backpressure();
        hold_requests++;
        repeat (12) begin
            build_packet(IP_VERSION_4, MIN_IHL, PROTO_UDP, $urandom, cfg_local, 0, 1'b0);
            send_frame();
        end
    endtask

    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        ip_verdict_t got;
        ip_verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            got.verdict   = verdict_t'(m_verdict);
            got.proto     = m_protocol_number;
            got.src       = m_source_address;
            got.dst       = m_dest_address;
            got.hdr_bytes = m_header_bytes;
            got.pkt_bytes = m_packet_bytes;
            if (pending_verdicts.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result beat: verdict %0d dst %h len %0d",
                             got.verdict, got.dst, got.pkt_bytes);
            end else begin
                want = pending_verdicts.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch exp: verdict %0d proto %h src %h dst %h hdr %0d len %0d",
                                 want.verdict, want.proto, want.src, want.dst,
                                 want.hdr_bytes, want.pkt_bytes);
                        $display("         got: verdict %0d proto %h src %h dst %h hdr %0d len %0d",
                                 got.verdict, got.proto, got.src, got.dst,
                                 got.hdr_bytes, got.pkt_bytes);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        send_idle_pct = 22;
        recv_idle_pct = 49;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_interface(32'hC0A8_0A05, 32'hFFFF_FF00, 1'b0);
        test_verdict_paths();
        test_short_packets();
        test_destination_rules();
        set_interface($urandom, 32'hFFFF_0000, 1'b0);
        test_random_traffic(8);

        send_idle_pct = 49;
        recv_idle_pct = 22;
        set_interface($urandom, 32'hFFFF_FFF0, 1'b0);
        test_random_traffic(8);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_interface($urandom, 32'hFFFF_FF00, 1'b0);
        test_random_traffic(8);

        wait_idle();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/ipv4rx_pkg.sv
rtl/core/ipv4rx_parse.sv
rtl/core/ipv4_receive_header_filter.sv
test/ipv4_receive_header_filter_tb.sv
